### rtl/ppfl_pkg.sv
// Shared types and codes for the per-CPU page free-list allocator.
package ppfl_pkg;

  // Request kinds carried on s_tuser.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status carried on m_tuser.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_PAGE  = 2'd1;
  localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

  // Configuration register indices.
  localparam logic REG_POOL_BASE  = 1'b0;
  localparam logic REG_POOL_LIMIT = 1'b1;

  localparam logic [31:0] POOL_BASE_RESET  = 32'h0000_0000;
  localparam logic [31:0] POOL_LIMIT_RESET = 32'h8800_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LINK
  } state_t;

endpackage

### rtl/ppfl_link_ram.sv
// Next-link store: single write port, single read port, registered read data.
module ppfl_link_ram #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = 20
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/per_cpu_page_free_list_allocator.sv
// Top level of the per-CPU page free-list allocator with stealing.
// Result: registered in the EXEC state, in the cycle after the beat is taken.
// Flow: no beat is taken in EXEC; a pop that leaves pages behind spends
//   the LINK state on the link RAM read, overlapped with taking the next beat.
// Reset: all lists empty, pool_base 0, pool_limit 0x8800_0000, output empty.
//   The link RAM is not cleared; only entries written by a free are ever read.
module per_cpu_page_free_list_allocator #(
  parameter int NUM_CPUS   = 8,
  parameter int NUM_PAGES  = 32768,   // power of two
  parameter int PAGE_BYTES = 4096     // power of two
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,    // [2:0] cpu_id, [34:3] page_addr, [39:35] zero
  input  logic        s_tuser,    // [0] opcode
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,    // [31:0] alloc_addr, [34:32] source_cpu, [39:35] zero
  output logic [1:0]  m_tuser,    // [1:0] status
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  import ppfl_pkg::*;

  localparam int OFF_W   = $clog2(PAGE_BYTES);
  localparam int FRAME_W = 32 - OFF_W;
  localparam int SLOT_W  = $clog2(NUM_PAGES);
  localparam int CPU_W   = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam logic [35:0] SPAN = 36'(NUM_PAGES) << OFF_W;

  // ---------------------------------------------------------------------
  // Configuration registers; writes are always taken.
  // ---------------------------------------------------------------------
  logic [31:0] pool_base;
  logic [31:0] pool_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= POOL_BASE_RESET;
      pool_limit <= POOL_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POOL_BASE:  pool_base  <= cfg_data;
        REG_POOL_LIMIT: pool_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------
  state_t state;
  state_t state_next;

  logic s_fire;
  logic out_valid;

  assign s_fire = s_tvalid && s_tready;

  // A beat is taken when idle or while the link read of the previous pop
  // lands; the head update and the next beat share that edge.
  always_comb begin
    s_tready = (state == ST_IDLE || state == ST_LINK) && (!out_valid || m_tready);
  end

  // Request registers
  logic             req_op;
  logic [CPU_W-1:0] req_cpu;
  logic [31:0]      req_addr;

  // cpu_id wraps modulo NUM_CPUS by repeated compare-and-subtract on 5 bits
  logic [4:0]       cpu_wrap;
  always_comb begin
    cpu_wrap = {2'b00, s_tdata[2:0]};
    for (int k = 0; k < 8; k++) begin
      if (cpu_wrap >= 5'(NUM_CPUS)) begin
        cpu_wrap = cpu_wrap - 5'(NUM_CPUS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      req_op   <= s_tuser;
      req_cpu  <= cpu_wrap[CPU_W-1:0];
      req_addr <= s_tdata[34:3];
    end
  end

  // ---------------------------------------------------------------------
  // List state: head frame and page count per CPU
  // ---------------------------------------------------------------------
  logic [FRAME_W-1:0] head  [NUM_CPUS];
  logic [31:0]        count [NUM_CPUS];
  logic [CPU_W-1:0]   pop_src;

  // ---------------------------------------------------------------------
  // EXEC decode
  // ---------------------------------------------------------------------
  logic               bad_free;
  logic [31:0]        addr_off;
  logic [FRAME_W-1:0] free_frame;
  logic [NUM_CPUS-1:0] nonempty;
  logic               found;
  logic [CPU_W-1:0]   src;
  logic               link_rd;
  logic [FRAME_W+SLOT_W-1:0] free_frame_ext;
  logic [FRAME_W+SLOT_W-1:0] pop_frame_ext;
  logic [CPU_W+2:0]   src_wide;

  logic               ram_wr_en;
  logic [SLOT_W-1:0]  ram_wr_addr;
  logic [FRAME_W-1:0] ram_wr_data;
  logic               ram_rd_en;
  logic [SLOT_W-1:0]  ram_rd_addr;
  logic [FRAME_W-1:0] ram_rd_data;

  assign addr_off   = req_addr - pool_base;
  assign free_frame = req_addr[31:OFF_W];

  always_comb begin
    bad_free = (req_addr[OFF_W-1:0] != '0) ||
               (req_addr < pool_base) ||
               (req_addr >= pool_limit) ||
               (36'(addr_off) >= SPAN);
  end

  // Own list first, otherwise the lowest-numbered non-empty list.
  always_comb begin
    for (int i = 0; i < NUM_CPUS; i++) begin
      nonempty[i] = (count[i] != 32'd0);
    end
    found = 1'b0;
    src   = req_cpu;
    if (nonempty[req_cpu]) begin
      found = 1'b1;
    end else begin
      for (int i = NUM_CPUS - 1; i >= 0; i--) begin
        if (nonempty[i]) begin
          found = 1'b1;
          src   = CPU_W'(i);
        end
      end
    end
  end

  // A pop that leaves the list non-empty fetches the page below.
  assign link_rd = (state == ST_EXEC) && (req_op == OP_ALLOC) && found &&
                   (count[src] != 32'd1);

  assign free_frame_ext = (FRAME_W+SLOT_W)'(free_frame);
  assign pop_frame_ext  = (FRAME_W+SLOT_W)'(head[src]);
  assign src_wide       = (CPU_W+3)'(src);

  assign ram_wr_en   = (state == ST_EXEC) && (req_op == OP_FREE) && !bad_free;
  assign ram_wr_addr = free_frame_ext[SLOT_W-1:0];
  assign ram_wr_data = head[req_cpu];
  assign ram_rd_en   = link_rd;
  assign ram_rd_addr = pop_frame_ext[SLOT_W-1:0];

  // Writes and reads both happen only in EXEC, and EXEC never directly follows
  // EXEC, so no forwarding path is needed.
  ppfl_link_ram #(
    .ADDR_W (SLOT_W),
    .DATA_W (FRAME_W)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // ---------------------------------------------------------------------
  // State machine
  // ---------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: state_next = s_fire ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_next = link_rd ? ST_LINK : ST_IDLE;
      ST_LINK: state_next = s_fire ? ST_EXEC : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counts are control state: reset empties every list.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        count[i] <= 32'd0;
      end
    end else if (state == ST_EXEC) begin
      if (req_op == OP_FREE) begin
        if (!bad_free) begin
          count[req_cpu] <= count[req_cpu] + 32'd1;
        end
      end else if (found) begin
        count[src] <= count[src] - 32'd1;
      end
    end
  end

  // Heads start at frame zero: a push onto an untouched list links to it.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        head[i] <= '0;
      end
      pop_src <= '0;
    end else if (state == ST_EXEC) begin
      if (req_op == OP_FREE && !bad_free) begin
        head[req_cpu] <= free_frame;
      end
      pop_src <= src;
    end else if (state == ST_LINK) begin
      head[pop_src] <= ram_rd_data;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic [1:0]  out_status;
  logic [31:0] out_addr;
  logic [2:0]  out_cpu;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EXEC) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      out_addr <= 32'd0;
      out_cpu  <= 3'd0;
      if (req_op == OP_FREE) begin
        out_status <= bad_free ? STATUS_BAD_ADDR : STATUS_OK;
      end else if (found) begin
        out_status <= STATUS_OK;
        out_addr   <= {head[src], {OFF_W{1'b0}}};
        out_cpu    <= src_wide[2:0];
      end else begin
        out_status <= STATUS_NO_PAGE;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_cpu, out_addr};
  assign m_tuser  = out_status;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_exec_after_beat: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> $past(s_tvalid && s_tready))
    else $error("EXEC entered without an accepted beat");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |=> out_valid)
    else $error("item finished without a result");

  a_link_after_pop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LINK) |-> ($past(state) == ST_EXEC && $past(req_op) == OP_ALLOC))
    else $error("link fetch without a preceding pop");

endmodule
